>>> src/imm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the integer matrix multiplier.
package imm_pkg;

	localparam int DIM_W  = 4;
	localparam int DATA_W = 32;

	typedef logic [DIM_W-1:0]         dim_t;
	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [1:0] {
		ACT_LOAD_A = 2'd0,
		ACT_LOAD_B = 2'd1,
		ACT_MULT   = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_MISMATCH   = 2'd2,
		ST_INCOMPLETE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_A_ROWS = 2'd0,
		CFG_A_COLS = 2'd1,
		CFG_B_ROWS = 2'd2,
		CFG_B_COLS = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_RUN,
		SQ_WAIT
	} seq_state_t;

	// MAC control that travels alongside the store read data
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

	// one finished product element handed to the output buffer
	typedef struct packed {
		logic valid;
		logic last;
	} emit_t;

	// zero acts as one, anything above the limit acts as the limit
	function automatic dim_t clamp_dim(dim_t v, dim_t max_d);
		dim_t r;
		r = v;
		if (v == '0) begin
			r = dim_t'(1);
		end else if (v > max_d) begin
			r = max_d;
		end
		return r;
	endfunction

endpackage

>>> src/imm_req_if.sv
`timescale 1ns / 1ps
// Request channel: load and multiply commands.
interface imm_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	imm_pkg::data_t    element_value;

	modport source(output valid, action, element_value, input ready);
	modport sink(input valid, action, element_value, output ready);
endinterface

>>> src/imm_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: product elements and error beats.
interface imm_rsp_if;
	logic              valid;
	logic              ready;
	imm_pkg::data_t    product_value;
	logic [1:0]        status;
	logic              last_item;

	modport source(output valid, product_value, status, last_item, input ready);
	modport sink(input valid, product_value, status, last_item, output ready);
endinterface

>>> src/integer_matrix_multiply.sv
`timescale 1ns / 1ps
// Top level of the integer matrix multiplier.
//
//  channel  | dir | payload                              | beat
//  ---------+-----+--------------------------------------+------------------------------
//  req      | in  | action, element_value                | one load or multiply command
//  rsp      | out | product_value, status, last_item     | one product element or error
//  cfg      | in  | cfg_wr_en, cfg_index, cfg_data       | one register write per cycle
//
// Loads can follow back to back. A load into a full matrix and a rejected
// multiply give one error beat each. A multiply gives a_rows * b_cols beats,
// all from one multiply-accumulate unit fed by the single read port of each
// store. Reset clears control state and fill counts and sets the size
// registers to their defaults; the stores are left as they are and need no
// clearing pass, since a fill count gates every read. A two-entry output
// buffer (register plus skid) lets req keep moving while a beat waits on rsp;
// req stalls while a multiply runs or the skid is full.
module integer_matrix_multiply #(
	parameter int MAX_DIM = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	imm_req_if.sink              req,
	imm_rsp_if.source            rsp,
	input  logic                 cfg_wr_en,
	input  logic [1:0]           cfg_index,
	input  imm_pkg::dim_t        cfg_data
);
	import imm_pkg::*;

	localparam int   DEPTH = MAX_DIM * MAX_DIM;
	localparam int   AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int   FW    = $clog2(DEPTH + 1);
	localparam int   SW    = 2 * DIM_W;
	localparam dim_t MAX_D = DIM_W'(MAX_DIM);

	// configuration, held as effective (clamped) sizes
	dim_t ar_q, ac_q, br_q, bc_q;
	logic [FW-1:0] a_fill_q, b_fill_q;
	logic [SW-1:0] a_size, b_size;
	logic          a_full, b_full;

	// request decode
	logic    req_fire;
	action_t act;
	logic    a_we, b_we, start;

	// result push into the output buffer
	logic    push_valid;
	data_t   push_value;
	status_t push_status;
	logic    push_last;

	// output register and skid entry
	logic    out_valid_q, skid_valid_q;
	data_t   out_value_q, skid_value_q;
	status_t out_status_q, skid_status_q;
	logic    out_last_q, skid_last_q;
	logic    out_fire, slot_ok;

	// sequencer and datapath
	logic [AW-1:0] a_raddr, b_raddr;
	logic [DATA_W-1:0] a_rdata, b_rdata;
	mac_ctl_t ctl_s1;
	emit_t    emit;
	logic     seq_idle;
	data_t    acc;
	logic     acc_done;

	assign a_size = SW'(ar_q) * SW'(ac_q);
	assign b_size = SW'(br_q) * SW'(bc_q);
	assign a_full = SW'(a_fill_q) >= a_size;
	assign b_full = SW'(b_fill_q) >= b_size;

	assign req.ready = seq_idle && !skid_valid_q;
	assign req_fire  = req.valid && req.ready;
	assign act       = action_t'(req.action);

	// command decode: store writes, error beats, multiply start
	always_comb begin
		a_we        = 1'b0;
		b_we        = 1'b0;
		start       = 1'b0;
		push_valid  = 1'b0;
		push_value  = '0;
		push_status = ST_OK;
		push_last   = 1'b1;
		if (req_fire) begin
			unique case (act)
				ACT_LOAD_A: begin
					if (a_full) begin
						push_valid  = 1'b1;
						push_status = ST_FULL;
					end else begin
						a_we = 1'b1;
					end
				end
				ACT_LOAD_B: begin
					if (b_full) begin
						push_valid  = 1'b1;
						push_status = ST_FULL;
					end else begin
						b_we = 1'b1;
					end
				end
				ACT_MULT: begin
					// size check wins over the completeness check
					if (ac_q != br_q) begin
						push_valid  = 1'b1;
						push_status = ST_MISMATCH;
					end else if (!a_full || !b_full) begin
						push_valid  = 1'b1;
						push_status = ST_INCOMPLETE;
					end else begin
						start = 1'b1;
					end
				end
				default: start = 1'b0;
			endcase
		end else if (emit.valid) begin
			push_valid = 1'b1;
			push_value = acc;
			push_last  = emit.last;
		end
	end

	// registers and fill counts; any register write restarts both loads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ar_q     <= clamp_dim(dim_t'(4), MAX_D);
			ac_q     <= clamp_dim(dim_t'(3), MAX_D);
			br_q     <= clamp_dim(dim_t'(3), MAX_D);
			bc_q     <= clamp_dim(dim_t'(4), MAX_D);
			a_fill_q <= '0;
			b_fill_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_A_ROWS: ar_q <= clamp_dim(cfg_data, MAX_D);
				CFG_A_COLS: ac_q <= clamp_dim(cfg_data, MAX_D);
				CFG_B_ROWS: br_q <= clamp_dim(cfg_data, MAX_D);
				CFG_B_COLS: bc_q <= clamp_dim(cfg_data, MAX_D);
				default:    ar_q <= ar_q;
			endcase
			a_fill_q <= '0;
			b_fill_q <= '0;
		end else begin
			if (a_we) a_fill_q <= a_fill_q + FW'(1);
			if (b_we) b_fill_q <= b_fill_q + FW'(1);
		end
	end

	// output buffer: the skid only fills while the output register is stalled
	assign out_fire = out_valid_q && rsp.ready;
	assign slot_ok  = (!out_valid_q || out_fire) && !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push_valid;
			end
		end else if (push_valid) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_value_q  <= skid_value_q;
				out_status_q <= skid_status_q;
				out_last_q   <= skid_last_q;
				skid_value_q  <= push_value;
				skid_status_q <= push_status;
				skid_last_q   <= push_last;
			end
		end else if (push_valid) begin
			if (!out_valid_q || out_fire) begin
				out_value_q  <= push_value;
				out_status_q <= push_status;
				out_last_q   <= push_last;
			end else begin
				skid_value_q  <= push_value;
				skid_status_q <= push_status;
				skid_last_q   <= push_last;
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.product_value = out_value_q;
	assign rsp.status        = out_status_q;
	assign rsp.last_item     = out_last_q;

	imm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_a_store (
		.clk  (clk),
		.we   (a_we),
		.waddr(a_fill_q[AW-1:0]),
		.wdata(req.element_value),
		.raddr(a_raddr),
		.rdata(a_rdata)
	);

	imm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_b_store (
		.clk  (clk),
		.we   (b_we),
		.waddr(b_fill_q[AW-1:0]),
		.wdata(req.element_value),
		.raddr(b_raddr),
		.rdata(b_rdata)
	);

	imm_seq #(
		.MAX_DIM(MAX_DIM)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.ar      (ar_q),
		.ac      (ac_q),
		.bc      (bc_q),
		.acc_done(acc_done),
		.slot_ok (slot_ok),
		.a_raddr (a_raddr),
		.b_raddr (b_raddr),
		.ctl_s1  (ctl_s1),
		.emit    (emit),
		.idle    (seq_idle)
	);

	imm_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl_s1(ctl_s1),
		.a_data(data_t'(a_rdata)),
		.b_data(data_t'(b_rdata)),
		.acc   (acc),
		.done  (acc_done)
	);

	// skid entry only ever sits behind a held output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat while the output register is empty");

	// fill counts never run past the configured matrix sizes
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(SW'(a_fill_q) <= a_size) && (SW'(b_fill_q) <= b_size))
		else $error("fill count beyond matrix size");

	// every beat that is not the last of its request is a good product element
	a_mid_beat_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.last_item) |-> (rsp.status == ST_OK))
		else $error("error status on a non-final beat");

	// a multiply walk never overlaps a taken command
	a_busy_no_req: assert property (@(posedge clk) disable iff (!arst_n)
		!seq_idle |-> !req_fire)
		else $error("command taken while multiply runs");

endmodule

>>> src/imm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port.
module imm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/imm_mac.sv
`timescale 1ns / 1ps
// Multiply-accumulate datapath: registered product, then 32-bit wrapping sum.
module imm_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  imm_pkg::mac_ctl_t ctl_s1,
	input  imm_pkg::data_t    a_data,
	input  imm_pkg::data_t    b_data,
	output imm_pkg::data_t    acc,
	output logic              done
);
	import imm_pkg::*;

	mac_ctl_t ctl_s2;
	data_t    prod_s2;
	data_t    acc_q;
	logic     done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_data * b_data;
		if (ctl_s2.valid) begin
			acc_q <= ctl_s2.first ? prod_s2 : acc_q + prod_s2;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

>>> src/imm_seq.sv
`timescale 1ns / 1ps
// Multiply sequencer: walks rows, columns and the inner index, drives store reads.
module imm_seq #(
	parameter int MAX_DIM = 8,
	localparam int DEPTH = MAX_DIM * MAX_DIM,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  imm_pkg::dim_t     ar,
	input  imm_pkg::dim_t     ac,
	input  imm_pkg::dim_t     bc,
	input  logic              acc_done,
	input  logic              slot_ok,
	output logic [AW-1:0]     a_raddr,
	output logic [AW-1:0]     b_raddr,
	output imm_pkg::mac_ctl_t ctl_s1,
	output imm_pkg::emit_t    emit,
	output logic              idle
);
	import imm_pkg::*;

	localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	seq_state_t    state_q, state_d;
	logic [IW-1:0] r_q, c_q, k_q;
	logic [AW-1:0] row_base_q, a_ptr_q, b_ptr_q;
	logic          rdy_q;
	logic          issue;
	logic          k_last, r_last, c_last;

	assign k_last = DIM_W'(k_q) == ac - dim_t'(1);
	assign r_last = DIM_W'(r_q) == ar - dim_t'(1);
	assign c_last = DIM_W'(c_q) == bc - dim_t'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: if (start) state_d = SQ_RUN;
			SQ_RUN:  if (k_last) state_d = SQ_WAIT;
			SQ_WAIT: begin
				if (rdy_q && slot_ok) begin
					state_d = (r_last && c_last) ? SQ_IDLE : SQ_RUN;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		issue      = 1'b0;
		emit       = '0;
		idle       = 1'b0;
		unique case (state_q)
			SQ_IDLE: idle = 1'b1;
			SQ_RUN:  issue = 1'b1;
			SQ_WAIT: begin
				emit.valid = rdy_q && slot_ok;
				emit.last  = r_last && c_last;
			end
			default: idle = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			ctl_s1  <= '0;
			rdy_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			ctl_s1.valid <= issue;
			ctl_s1.first <= k_q == '0;
			ctl_s1.last  <= k_last;
			if (emit.valid) begin
				rdy_q <= 1'b0;
			end else if (acc_done) begin
				rdy_q <= 1'b1;
			end
		end
	end

	// index walk: A reads step along a row, B reads step down a column
	always_ff @(posedge clk) begin
		if (start) begin
			r_q        <= '0;
			c_q        <= '0;
			k_q        <= '0;
			row_base_q <= '0;
			a_ptr_q    <= '0;
			b_ptr_q    <= '0;
		end else if (issue) begin
			k_q     <= k_q + IW'(1);
			a_ptr_q <= a_ptr_q + AW'(1);
			b_ptr_q <= b_ptr_q + AW'(bc);
		end else if (emit.valid && !emit.last) begin
			k_q <= '0;
			if (c_last) begin
				c_q        <= '0;
				r_q        <= r_q + IW'(1);
				row_base_q <= row_base_q + AW'(ac);
				a_ptr_q    <= row_base_q + AW'(ac);
				b_ptr_q    <= '0;
			end else begin
				c_q     <= c_q + IW'(1);
				a_ptr_q <= row_base_q;
				b_ptr_q <= AW'(c_q) + AW'(1);
			end
		end
	end

	assign a_raddr = a_ptr_q;
	assign b_raddr = b_ptr_q;

endmodule
